@@ src/spm_pkg.sv @@
// Shared widths and types for the sparse polynomial multiplier.
// No dependencies; compiled first.
package spm_pkg;

    // Term field widths
    localparam int COEF_W = 32;
    localparam int EXP_W  = 8;
    localparam int PEXP_W = 9;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic [EXP_W-1:0]         exp_t;
    typedef logic [PEXP_W-1:0]        pexp_t;

endpackage

@@ src/spm_if.sv @@
// Valid/ready channel interfaces for input terms and product terms.
// Depends on spm_pkg for the field types.
interface spm_in_if;
    logic              valid;
    logic              ready;
    spm_pkg::coef_t    coefficient;
    spm_pkg::exp_t     exponent;
    logic              last_term;

    modport source (output valid, output coefficient, output exponent, output last_term,
                    input ready);
    modport sink   (input valid, input coefficient, input exponent, input last_term,
                    output ready);
endinterface

interface spm_out_if;
    logic              valid;
    logic              ready;
    spm_pkg::coef_t    product_coefficient;
    spm_pkg::pexp_t    product_exponent;
    logic              truncated;
    logic              last_result;

    modport source (output valid, output product_coefficient, output product_exponent,
                    output truncated, output last_result, input ready);
    modport sink   (input valid, input product_coefficient, input product_exponent,
                    input truncated, input last_result, output ready);
endinterface

@@ src/sparse_polynomial_multiply.sv @@
// Sparse polynomial multiplier: first-factor terms are accepted one beat per cycle; each
// second-factor term is multiplied against every stored first term through one shared
// 32x32 multiplier, with one read-modify-write of the exponent store per stored term.
// After the last term the store is scanned from the highest to the lowest product
// exponent, holding on output stalls. After reset all 2*EXP_MAX+1 entries (511 by
// default) of the exponent store are cleared, during which no input beat is accepted.
module sparse_polynomial_multiply #(
    parameter int MAX_TERMS = 8,
    parameter int EXP_MAX   = 255
) (
    input  logic       clk,
    input  logic       rst_n,
    spm_in_if.sink     terms,
    spm_out_if.source  products
);

    localparam int CW        = $clog2(MAX_TERMS + 1);
    localparam int IW        = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int SUM_DEPTH = 2 * EXP_MAX + 1;
    localparam int AW        = $clog2(SUM_DEPTH);
    localparam int XW        = 11;
    localparam int CO        = spm_pkg::COEF_W;
    localparam int EW        = spm_pkg::EXP_W;
    localparam int PW        = spm_pkg::PEXP_W;

    // Sequencer states
    localparam logic [2:0] ST_CLR      = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_MUL      = 3'd2;
    localparam logic [2:0] ST_DRAIN    = 3'd3;
    localparam logic [2:0] ST_FINISH   = 3'd4;
    localparam logic [2:0] ST_EMIT_RD  = 3'd5;
    localparam logic [2:0] ST_EMIT_CHK = 3'd6;

    // Control registers
    logic [2:0]    state_reg, state_next;
    logic          phase_reg, phase_next;
    logic [CW-1:0] first_count_reg, first_count_next;
    logic [CW-1:0] second_count_reg, second_count_next;
    logic          overflow_reg, overflow_next;
    logic          any_reg, any_next;
    logic [AW-1:0] max_reg, max_next;
    logic [AW-1:0] min_reg, min_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          last_reg, last_next;
    logic [AW-1:0] scan_reg, scan_next;
    logic          valid_s1_reg, valid_s1_next;
    logic          out_valid_reg, out_valid_next;

    // Payload registers
    logic [CO-1:0] coef_reg;
    logic [EW-1:0] exp_reg;
    logic [CO-1:0] first_coef_reg [MAX_TERMS];
    logic [EW-1:0] first_exp_reg [MAX_TERMS];
    logic [AW-1:0] sum_s1_reg;
    logic [CO-1:0] prod_s1_reg;
    logic          fwd_s1_reg;
    logic [CO-1:0] wdata_reg;
    logic [CO:0]   rd_reg;
    logic [CO-1:0] out_coef_reg;
    logic [PW-1:0] out_exp_reg;
    logic          out_trunc_reg;
    logic          out_last_reg;

    // Exponent store: {present, accumulated coefficient}
    logic [CO:0]   acc_mem [SUM_DEPTH];

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [CO:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;

    logic          accept;
    logic          exp_ok;
    logic          store_first;
    logic          take_second;
    logic          issue;
    logic [PW-1:0] cur_sum;
    logic [AW-1:0] cur_addr;
    logic [CO-1:0] prod_low;
    logic [CO-1:0] acc_base;
    logic [CO-1:0] acc_sum;
    logic          out_free;
    logic          emit_load;
    logic          at_end;
    logic          idx_last;

    assign terms.ready = (state_reg == ST_IDLE);
    assign accept      = terms.valid && terms.ready;
    assign exp_ok      = (XW'(terms.exponent) <= XW'(EXP_MAX));
    assign store_first = accept && !phase_reg && (first_count_reg < CW'(MAX_TERMS)) && exp_ok;
    assign take_second = accept && phase_reg && (second_count_reg < CW'(MAX_TERMS)) && exp_ok;

    // Shared multiply-accumulate datapath
    assign issue    = (state_reg == ST_MUL);
    assign cur_sum  = PW'(exp_reg) + PW'(first_exp_reg[idx_reg]);
    assign cur_addr = AW'(cur_sum);
    assign prod_low = coef_reg * first_coef_reg[idx_reg];
    assign acc_base = fwd_s1_reg ? wdata_reg : rd_reg[CO-1:0];
    assign acc_sum  = acc_base + prod_s1_reg;
    assign idx_last = ((CW'(idx_reg) + CW'(1)) == first_count_reg);

    // Emission scan
    assign out_free  = !out_valid_reg || products.ready;
    assign at_end    = (scan_reg == min_reg);
    assign emit_load = (state_reg == ST_EMIT_CHK) && rd_reg[CO] && out_free;

    // Memory port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = scan_reg;
        mem_wdata = '0;
        if (valid_s1_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = sum_s1_reg;
            mem_wdata = {1'b1, acc_sum};
        end
        else if (state_reg == ST_CLR || emit_load)
        begin
            mem_we = 1'b1;
        end
        mem_raddr = issue ? cur_addr : scan_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            acc_mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= acc_mem[mem_raddr];
    end

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        overflow_next     = overflow_reg;
        any_next          = any_reg;
        max_next          = max_reg;
        min_next          = min_reg;
        idx_next          = idx_reg;
        last_next         = last_reg;
        scan_next         = scan_reg;
        valid_s1_next     = issue;
        out_valid_next    = products.ready ? 1'b0 : out_valid_reg;
        if (emit_load)
        begin
            out_valid_next = 1'b1;
        end

        case (state_reg)
            ST_CLR:
            begin
                // stop on the top entry so the scan pointer stays inside the store
                if (scan_reg == AW'(SUM_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    last_next = terms.last_term;
                    if (!phase_reg)
                    begin
                        if (store_first)
                        begin
                            first_count_next = first_count_reg + CW'(1);
                        end
                        else
                        begin
                            overflow_next = 1'b1;
                        end
                        if (terms.last_term)
                        begin
                            phase_next = 1'b1;
                        end
                    end
                    else
                    begin
                        idx_next = '0;
                        if (take_second)
                        begin
                            second_count_next = second_count_reg + CW'(1);
                        end
                        else
                        begin
                            overflow_next = 1'b1;
                        end
                        if (take_second && first_count_reg != '0)
                        begin
                            state_next = ST_MUL;
                        end
                        else if (terms.last_term)
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                end
            end
            ST_MUL:
            begin
                // track the span of touched exponents
                any_next = 1'b1;
                if (!any_reg || cur_addr > max_reg)
                begin
                    max_next = cur_addr;
                end
                if (!any_reg || cur_addr < min_reg)
                begin
                    min_next = cur_addr;
                end
                idx_next = idx_reg + IW'(1);
                if (idx_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = last_reg ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH:
            begin
                scan_next = max_reg;
                if (any_reg)
                begin
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    state_next        = ST_IDLE;
                    phase_next        = 1'b0;
                    first_count_next  = '0;
                    second_count_next = '0;
                    overflow_next     = 1'b0;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_CHK;
            end
            ST_EMIT_CHK:
            begin
                // hold on a present entry until the output register frees
                if (!rd_reg[CO] || out_free)
                begin
                    if (at_end)
                    begin
                        state_next        = ST_IDLE;
                        phase_next        = 1'b0;
                        first_count_next  = '0;
                        second_count_next = '0;
                        overflow_next     = 1'b0;
                        any_next          = 1'b0;
                    end
                    else
                    begin
                        scan_next  = scan_reg - AW'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLR;
            phase_reg        <= 1'b0;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            overflow_reg     <= 1'b0;
            any_reg          <= 1'b0;
            max_reg          <= '0;
            min_reg          <= '0;
            idx_reg          <= '0;
            last_reg         <= 1'b0;
            scan_reg         <= '0;
            valid_s1_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            overflow_reg     <= overflow_next;
            any_reg          <= any_next;
            max_reg          <= max_next;
            min_reg          <= min_next;
            idx_reg          <= idx_next;
            last_reg         <= last_next;
            scan_reg         <= scan_next;
            valid_s1_reg     <= valid_s1_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload: term capture, multiply stage, result register
    always_ff @(posedge clk)
    begin
        if (store_first)
        begin
            first_coef_reg[IW'(first_count_reg)] <= terms.coefficient;
            first_exp_reg[IW'(first_count_reg)]  <= terms.exponent;
        end
        if (accept)
        begin
            coef_reg <= terms.coefficient;
            exp_reg  <= terms.exponent;
        end
        sum_s1_reg  <= cur_addr;
        prod_s1_reg <= prod_low;
        // same sum written this edge: read data is stale, take the written value
        fwd_s1_reg  <= issue && valid_s1_reg && (cur_addr == sum_s1_reg);
        if (valid_s1_reg)
        begin
            wdata_reg <= acc_sum;
        end
        if (emit_load)
        begin
            out_coef_reg  <= rd_reg[CO-1:0];
            out_exp_reg   <= PW'(scan_reg);
            out_trunc_reg <= overflow_reg;
            out_last_reg  <= at_end;
        end
    end

    assign products.valid               = out_valid_reg;
    assign products.product_coefficient = $signed(out_coef_reg);
    assign products.product_exponent    = out_exp_reg;
    assign products.truncated           = out_trunc_reg;
    assign products.last_result         = out_last_reg;

endmodule

@@ bench/sparse_polynomial_multiply_tb.sv @@
// Self-checking bench for sparse_polynomial_multiply: sends pairs of factors over the term
// channel and checks every product beat against an in-bench polynomial product.
// Depends on spm_pkg, spm_in_if / spm_out_if and the sparse_polynomial_multiply RTL.
`timescale 1ns / 1ps

module sparse_polynomial_multiply_tb;

    localparam int MAX_TERMS    = 8;
    localparam int EXP_MAX      = 255;
    localparam int SUM_DEPTH    = 2 * EXP_MAX + 1;
    localparam int RANDOM_TERMS = 350;
    localparam int DRAIN_CYCLES = 2 * SUM_DEPTH + 100;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        spm_pkg::coef_t product_coefficient;
        spm_pkg::pexp_t product_exponent;
        logic           truncated;
        logic           last_result;
    } product_beat_t;

    logic clk;
    logic rst_n;

    spm_in_if  term_bus ();
    spm_out_if product_bus ();

    sparse_polynomial_multiply #(
        .MAX_TERMS (MAX_TERMS),
        .EXP_MAX   (EXP_MAX)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .terms    (term_bus),
        .products (product_bus)
    );

    // Multiplier state mirror
    bit             second_factor;
    spm_pkg::coef_t kept_coef [MAX_TERMS];
    spm_pkg::exp_t  kept_exp [MAX_TERMS];
    int             kept_count;
    int             second_taken;
    bit             terms_dropped;
    logic [31:0]    exp_sums [SUM_DEPTH];
    bit             exp_hit [SUM_DEPTH];

    product_beat_t product_terms_due [$];

    bit quiet;
    int error_count;
    int terms_sent;
    int random_terms;
    int pairs_done;
    int truncated_pairs;
    int beats_checked;
    int cycle_count;

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d beats outstanding", cycle_count,
                     product_terms_due.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic int draw_factor_size();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_TERMS + 1, MAX_TERMS + 3)
                                            : $urandom_range(1, MAX_TERMS);
    endfunction

    // Mostly full-range; some small values for cancellation, some corner values
    function automatic spm_pkg::coef_t draw_coef();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            case ($urandom_range(0, 4))
                0: return spm_pkg::coef_t'(32'h8000_0000);
                1: return spm_pkg::coef_t'(32'h7fff_ffff);
                2: return spm_pkg::coef_t'(0);
                3: return spm_pkg::coef_t'(-1);
                default: return spm_pkg::coef_t'(1);
            endcase
        end
        if (pick <= 2)
            return spm_pkg::coef_t'($urandom_range(0, 8) - 4);
        return spm_pkg::coef_t'($urandom);
    endfunction

    function automatic void clear_product_store();
        second_factor = 1'b0;
        kept_count    = 0;
        second_taken  = 0;
        terms_dropped = 1'b0;
        foreach (exp_sums[k])
        begin
            exp_sums[k] = '0;
            exp_hit[k]  = 1'b0;
        end
    endfunction

    // Fold one accepted term into the product; queue the result beats at the pair's end
    function automatic void absorb_term(spm_pkg::coef_t coef, spm_pkg::exp_t expo,
                                        logic last);
        logic [31:0]   partial;
        int            idx;
        int            beats;
        product_beat_t beat;
        if (!second_factor)
        begin
            if (kept_count < MAX_TERMS && expo <= EXP_MAX)
            begin
                kept_coef[kept_count] = coef;
                kept_exp[kept_count]  = expo;
                kept_count++;
            end
            else
                terms_dropped = 1'b1;
            if (last)
                second_factor = 1'b1;
            return;
        end
        if (second_taken < MAX_TERMS && expo <= EXP_MAX)
        begin
            for (int i = 0; i < kept_count; i++)
            begin
                idx = expo + kept_exp[i];
                if (idx < SUM_DEPTH)
                begin
                    partial       = coef * kept_coef[i];
                    exp_sums[idx] = exp_sums[idx] + partial;
                    exp_hit[idx]  = 1'b1;
                end
            end
            second_taken++;
        end
        else
            terms_dropped = 1'b1;
        if (!last)
            return;
        // Highest exponent first, zero sums included
        beats = 0;
        for (int k = SUM_DEPTH - 1; k >= 0; k--)
        begin
            if (exp_hit[k])
            begin
                beat.product_coefficient = spm_pkg::coef_t'(exp_sums[k]);
                beat.product_exponent    = spm_pkg::pexp_t'(k);
                beat.truncated           = terms_dropped;
                beat.last_result         = 1'b0;
                product_terms_due.push_back(beat);
                beats++;
            end
        end
        if (beats > 0)
            product_terms_due[product_terms_due.size() - 1].last_result = 1'b1;
        pairs_done++;
        if (terms_dropped)
            truncated_pairs++;
        clear_product_store();
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        error_count++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    endtask

    // Drive one term beat and hold it until the block takes it
    task automatic send_term(input spm_pkg::coef_t coef, input spm_pkg::exp_t expo,
                             input logic last);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            term_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        term_bus.valid       <= 1'b1;
        term_bus.coefficient <= coef;
        term_bus.exponent    <= expo;
        term_bus.last_term   <= last;
        @(posedge clk);
        while (!term_bus.ready)
            @(posedge clk);
        absorb_term(coef, expo, last);
        terms_sent++;
    endtask

    // Sender holds off until every queued product beat has come back
    task automatic wait_for_products();
        term_bus.valid <= 1'b0;
        while (product_terms_due.size() != 0)
            @(posedge clk);
    endtask

    // Product channel: random stalls, every beat checked in order
    initial
    begin : product_checker
        int            stall;
        product_beat_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                product_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            product_bus.ready <= 1'b1;
            @(posedge clk);
            while (!product_bus.valid)
                @(posedge clk);
            beats_checked++;
            if (product_terms_due.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected product beat, expected none, got %0h x^%0d",
                         $time, product_bus.product_coefficient,
                         product_bus.product_exponent);
            end
            else
            begin
                want = product_terms_due.pop_front();
                if (product_bus.product_coefficient !== want.product_coefficient)
                    report_mismatch("product_coefficient", want.product_coefficient,
                                    product_bus.product_coefficient);
                if (product_bus.product_exponent !== want.product_exponent)
                    report_mismatch("product_exponent", want.product_exponent,
                                    product_bus.product_exponent);
                if (product_bus.truncated !== want.truncated)
                    report_mismatch("truncated", want.truncated, product_bus.truncated);
                if (product_bus.last_result !== want.last_result)
                    report_mismatch("last_result", want.last_result, product_bus.last_result);
            end
        end
    end

    // Largest magnitudes at the exponent extremes; both products wrap
    task automatic test_extremes();
        send_term(spm_pkg::coef_t'(32'h7fff_ffff), spm_pkg::exp_t'(255), 1'b1);
        send_term(spm_pkg::coef_t'(32'h7fff_ffff), spm_pkg::exp_t'(255), 1'b1);
        send_term(spm_pkg::coef_t'(32'h8000_0000), spm_pkg::exp_t'(0), 1'b1);
        send_term(spm_pkg::coef_t'(32'h8000_0000), spm_pkg::exp_t'(0), 1'b1);
    endtask

    // (x + 1)(x - x^2): the x^2 terms cancel and the zero sum is still emitted
    task automatic test_cancellation();
        send_term(spm_pkg::coef_t'(1), spm_pkg::exp_t'(1), 1'b0);
        send_term(spm_pkg::coef_t'(1), spm_pkg::exp_t'(0), 1'b1);
        send_term(spm_pkg::coef_t'(1), spm_pkg::exp_t'(1), 1'b0);
        send_term(spm_pkg::coef_t'(-1), spm_pkg::exp_t'(2), 1'b1);
    endtask

    // One term too many in both factors; the marked term of each is the dropped one
    task automatic test_truncation();
        for (int i = 0; i <= MAX_TERMS; i++)
            send_term(spm_pkg::coef_t'(i + 1), spm_pkg::exp_t'(i * 31), i == MAX_TERMS);
        for (int i = 0; i <= MAX_TERMS; i++)
            send_term(spm_pkg::coef_t'(-(i + 3)), spm_pkg::exp_t'(i * 2), i == MAX_TERMS);
    endtask

    // Random pairs: sizes up to a few past the store, exponents wide or bunched
    task automatic test_random_pairs();
        int n_first;
        int n_second;
        int window;
        int base;
        int pairs;
        pairs = 0;
        while (random_terms < RANDOM_TERMS)
        begin
            quiet    = ($urandom_range(0, 4) == 0);
            n_first  = draw_factor_size();
            n_second = draw_factor_size();
            window   = $urandom_range(0, 1) ? 255 : $urandom_range(1, 7);
            base     = $urandom_range(0, 255 - window);
            for (int i = 0; i < n_first; i++)
                send_term(draw_coef(), spm_pkg::exp_t'(base + $urandom_range(0, window)),
                          i == n_first - 1);
            window = $urandom_range(0, 1) ? 255 : $urandom_range(1, 7);
            base   = $urandom_range(0, 255 - window);
            for (int i = 0; i < n_second; i++)
                send_term(draw_coef(), spm_pkg::exp_t'(base + $urandom_range(0, window)),
                          i == n_second - 1);
            random_terms += n_first + n_second;
            pairs++;
            if (pairs % 8 == 0)
                wait_for_products();
        end
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        term_bus.valid         = 1'b0;
        term_bus.coefficient   = '0;
        term_bus.exponent      = '0;
        term_bus.last_term     = 1'b0;
        product_bus.ready      = 1'b0;
        quiet                  = 1'b0;
        error_count            = 0;
        terms_sent             = 0;
        random_terms           = 0;
        pairs_done             = 0;
        truncated_pairs        = 0;
        beats_checked          = 0;
        cycle_count            = 0;
        clear_product_store();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_extremes();
        wait_for_products();
        test_cancellation();
        test_truncation();
        wait_for_products();
        test_random_pairs();

        // Drain: all beats back, then leave time for a stray one to show
        wait_for_products();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Multiplied %0d factor pairs from %0d terms, %0d with dropped terms,",
                 pairs_done, terms_sent, truncated_pairs);
        $display("checked %0d product beats under random source and sink stalls",
                 beats_checked);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
src/spm_pkg.sv
src/spm_if.sv
src/sparse_polynomial_multiply.sv
bench/sparse_polynomial_multiply_tb.sv
